// ===== src/gsh_pkg.sv =====
// Shared constants, types and helpers of the grid spatial hash.
`default_nettype none
package gsh_pkg;

	localparam int MAX_NODES   = 1024;
	localparam int GRID_BITS   = 5;
	localparam int COORD_BITS  = 16;
	localparam int MAX_MATCHES = 64;

	localparam int NODE_AW    = $clog2(MAX_NODES);
	localparam int GRID_SIDE  = 1 << GRID_BITS;
	localparam int CELL_AW    = 2 * GRID_BITS;
	localparam int GRID_CELLS = 1 << CELL_AW;
	localparam int MIN_SHIFT  = COORD_BITS - GRID_BITS;

	localparam int CMD_W      = 2;
	localparam int FIELD_W    = 16;
	localparam int IDX_W      = 10;
	localparam int SHIFT_W    = 4;
	localparam int RING_W     = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int SEFF_W     = 5;

	localparam int MUL_W  = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
	localparam int DIST_W = 2 * COORD_BITS + 1;
	localparam int GXW    = ((GRID_BITS > RING_W) ? GRID_BITS : RING_W) + 2;
	localparam int EXT_W  = GXW - 1;
	localparam int CNT_W  = $clog2(MAX_MATCHES + 1);
	localparam int CLR_N  = (GRID_CELLS > MAX_NODES) ? GRID_CELLS : MAX_NODES;
	localparam int CLR_W  = $clog2(CLR_N);

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT  = 2'd0,
		CMD_NEAREST = 2'd1,
		CMD_RADIUS  = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CELL_SHIFT = 1'b0,
		REG_RING_LIMIT = 1'b1
	} reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_INS_RD,
		ST_INS_WR,
		ST_SETUP,
		ST_CELL,
		ST_CELL_CHK,
		ST_NODE_RD,
		ST_NODE_DX,
		ST_NODE_DY,
		ST_EVAL,
		ST_RING_SQ,
		ST_RING_CHK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic               occ;
		logic [NODE_AW-1:0] head;
		logic [NODE_AW-1:0] tail;
	} cell_t;

	function automatic logic [IDX_W-1:0] to_idx(input logic [NODE_AW-1:0] n);
		logic [31:0] t;
		t = 32'(n);
		return t[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== src/gsh_intf.sv =====
// Command, result and register write channels of the grid spatial hash.
`default_nettype none
interface gsh_req_if;
	logic                         valid;
	logic                         ready;
	logic [gsh_pkg::CMD_W-1:0]    cmd;
	logic [gsh_pkg::FIELD_W-1:0]  point_x;
	logic [gsh_pkg::FIELD_W-1:0]  point_y;
	logic [gsh_pkg::IDX_W-1:0]    node_index;
	logic [gsh_pkg::FIELD_W-1:0]  radius;
	modport source(output valid, cmd, point_x, point_y, node_index, radius, input ready);
	modport sink(input valid, cmd, point_x, point_y, node_index, radius, output ready);
endinterface

interface gsh_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic [gsh_pkg::IDX_W-1:0] result_index;
	logic                      last;
	logic                      overflow;
	modport source(output valid, found, result_index, last, overflow, input ready);
	modport sink(input valid, found, result_index, last, overflow, output ready);
endinterface

interface gsh_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [gsh_pkg::CFG_IDX_W-1:0]  index;
	logic [gsh_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/grid_spatial_hash_neighbor_search.sv =====
// Top level of the grid spatial hash: sequencer, point and cell stores, result register.
//
// Points are inserted under an index into a square grid of cells, each cell keeping a
// linked list of its points in insertion order; nearest and within-radius queries walk
// those lists. One command is taken at a time and every command returns one or more
// result beats, the final one flagged by last. After reset the block sweeps the cell
// occupancy and index-used stores, one entry a cycle, before taking the first command;
// register writes are taken throughout. A query reads each cell it visits inside the
// grid and checks its occupancy, passing over cells outside the grid without a read;
// for each stored point it reads, one shared squaring unit computes dx^2 and then dy^2
// before the point is evaluated. A nearest query squares the ring extent and makes a
// stop test after each ring. A finished result waits in the output register while the
// next work proceeds.
`default_nettype none
module grid_spatial_hash_neighbor_search (
	input wire logic  clk,
	input wire logic  arst_n,
	gsh_req_if.sink   req,
	gsh_rsp_if.source rsp,
	gsh_cfg_if.sink   cfg
);
	localparam int CW = gsh_pkg::COORD_BITS;
	localparam int NA = gsh_pkg::NODE_AW;
	localparam int GB = gsh_pkg::GRID_BITS;

	gsh_pkg::state_t state_q, state_d;

	// Registers and clearing sweep
	logic [gsh_pkg::SHIFT_W-1:0] shift_q;
	logic [gsh_pkg::RING_W-1:0]  rlim_q;
	logic [gsh_pkg::CLR_W-1:0]   clr_q;

	// Latched command
	logic [gsh_pkg::CMD_W-1:0]   cmd_q;
	logic [CW-1:0]               qx_q, qy_q;
	logic [gsh_pkg::IDX_W-1:0]   idx_q;
	logic [gsh_pkg::FIELD_W-1:0] rad_q;

	// Scan state
	logic signed [gsh_pkg::GXW-1:0] cx_q, cy_q, gx_q, gy_q;
	logic [gsh_pkg::EXT_W-1:0]      ext_q;
	logic [NA-1:0]                  n_q, tail_q;
	logic                           have_q;
	logic [gsh_pkg::DIST_W-1:0]     best_q, d_q;
	logic [NA-1:0]                  best_idx_q;
	logic [2*gsh_pkg::MUL_W-1:0]    dx2_q;
	logic [31:0]                    r2_q;
	logic [2*gsh_pkg::EXT_W-1:0]    rsq_q;
	logic                           pend_v_q, ovf_q;
	logic [NA-1:0]                  pend_idx_q;
	logic [gsh_pkg::CNT_W-1:0]      cnt_q;
	logic                           res_f_q;
	logic [gsh_pkg::IDX_W-1:0]      res_idx_q;

	// Result register
	logic                        out_v_q, o_found_q, o_last_q, o_ovf_q;
	logic [gsh_pkg::IDX_W-1:0]   o_idx_q;
	logic                        out_load, ld_found, ld_last, ld_ovf;
	logic [gsh_pkg::IDX_W-1:0]   ld_idx;
	logic                        out_free;

	// RAM ports
	logic                  xy_we, xy_re, nxt_we, nxt_re, used_we, used_re, cell_we, cell_re;
	logic [NA-1:0]         xy_waddr, nxt_waddr, nxt_wdata, used_addr, node_raddr;
	logic [2*CW-1:0]       xy_rd;
	logic [NA-1:0]         nxt_rd;
	logic                  used_wdata, used_rd;
	logic [gsh_pkg::CELL_AW-1:0] cell_waddr, cell_raddr;
	gsh_pkg::cell_t        cell_wdata, cell_rd;

	// Shared unit
	logic [gsh_pkg::MUL_W-1:0]   alu_a, alu_b;
	logic [2*gsh_pkg::MUL_W-1:0] alu_sq;

	// Derived values
	logic [gsh_pkg::SEFF_W-1:0]     s_eff;
	logic [CW-1:0]                  shx, shy;
	logic [GB-1:0]                  cx_c, cy_c;
	logic [gsh_pkg::CELL_AW-1:0]    ins_cell;
	logic [31:0]                    sp32;
	logic [gsh_pkg::EXT_W-1:0]      span_c, ext_new;
	logic signed [gsh_pkg::GXW-1:0] ext_s, ext_new_s, ext_inc_s, cxs_c, cys_c;
	logic signed [gsh_pkg::GXW-1:0] lo_x, hi_x, lo_y, hi_y, gx_n, gy_n;
	logic                           is_rad, edge_col, adv_done, in_grid;
	logic                           ins_bad, match, need_emit, stall, better, ring_stop;
	logic [63:0]                    reach2;
	logic [NA-1:0]                  idx_addr;
	logic [CW-1:0]                  node_x, node_y;
	logic [31:0]                    idx32;
	gsh_pkg::state_t                end_st;

	assign req.ready = (state_q == gsh_pkg::ST_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid        = out_v_q;
	assign rsp.found        = o_found_q;
	assign rsp.result_index = o_idx_q;
	assign rsp.last         = o_last_q;
	assign rsp.overflow     = o_ovf_q;

	assign out_free = !out_v_q || rsp.ready;

	// Cell geometry: raise the shift so every coordinate lands inside the grid
	always_comb begin
		s_eff = (32'(shift_q) < gsh_pkg::MIN_SHIFT) ? gsh_pkg::SEFF_W'(gsh_pkg::MIN_SHIFT)
		                                             : gsh_pkg::SEFF_W'(shift_q);
		shx      = qx_q >> s_eff;
		shy      = qy_q >> s_eff;
		cx_c     = shx[GB-1:0];
		cy_c     = shy[GB-1:0];
		ins_cell = {cy_c, cx_c};
		cxs_c    = $signed(gsh_pkg::GXW'(cx_c));
		cys_c    = $signed(gsh_pkg::GXW'(cy_c));
		// A span past the grid side reaches no further occupied cell, so clamp it
		sp32     = (32'(rad_q) + (32'd1 << s_eff) - 32'd1) >> s_eff;
		span_c   = (sp32 > 32'(gsh_pkg::GRID_SIDE)) ? gsh_pkg::EXT_W'(gsh_pkg::GRID_SIDE)
		                                            : sp32[gsh_pkg::EXT_W-1:0];
		is_rad   = (cmd_q == gsh_pkg::CMD_RADIUS);
		ext_new  = is_rad ? span_c : '0;
		ext_new_s = $signed({1'b0, ext_new});
		ext_s     = $signed({1'b0, ext_q});
		ext_inc_s = $signed({1'b0, ext_q + 1'b1});
		lo_x = cx_q - ext_s;
		hi_x = cx_q + ext_s;
		lo_y = cy_q - ext_s;
		hi_y = cy_q + ext_s;
	end

	// Cell walk: x outer, y inner; a nearest ring visits only its rim
	always_comb begin
		edge_col = is_rad || (gx_q == lo_x) || (gx_q == hi_x);
		gx_n     = gx_q;
		gy_n     = gy_q;
		adv_done = 1'b0;
		if (edge_col ? (gy_q != hi_y) : (gy_q == lo_y)) begin
			gy_n = edge_col ? (gy_q + $signed(gsh_pkg::GXW'(1))) : hi_y;
		end else if (gx_q != hi_x) begin
			gx_n = gx_q + $signed(gsh_pkg::GXW'(1));
			gy_n = lo_y;
		end else begin
			adv_done = 1'b1;
		end
		in_grid = (gx_q >= 0) && (gy_q >= 0)
		       && (gx_q < $signed(gsh_pkg::GXW'(gsh_pkg::GRID_SIDE)))
		       && (gy_q < $signed(gsh_pkg::GXW'(gsh_pkg::GRID_SIDE)));
		end_st = is_rad ? gsh_pkg::ST_FIN : gsh_pkg::ST_RING_SQ;
	end

	always_comb begin
		idx32     = 32'(idx_q);
		idx_addr  = idx32[NA-1:0];
		ins_bad   = (idx32 >= 32'(gsh_pkg::MAX_NODES)) || used_rd;
		node_x    = xy_rd[2*CW-1:CW];
		node_y    = xy_rd[CW-1:0];
		match     = 64'(d_q) <= 64'(r2_q);
		need_emit = is_rad && match && pend_v_q
		         && (32'(cnt_q) < gsh_pkg::MAX_MATCHES);
		stall     = need_emit && !out_free;
		better    = !have_q || (d_q < best_q);
		reach2    = 64'(rsq_q) << {s_eff, 1'b0};
		ring_stop = (have_q && (reach2 >= 64'(best_q)))
		         || (ext_q == gsh_pkg::EXT_W'(rlim_q));
	end

	// Next state, RAM controls and result loading
	always_comb begin
		state_d    = state_q;
		xy_we      = 1'b0;
		xy_re      = 1'b0;
		nxt_we     = 1'b0;
		nxt_re     = 1'b0;
		used_we    = 1'b0;
		used_re    = 1'b0;
		cell_we    = 1'b0;
		cell_re    = 1'b0;
		xy_waddr   = idx_addr;
		nxt_waddr  = cell_rd.tail;
		nxt_wdata  = idx_addr;
		used_addr  = idx_addr;
		used_wdata = 1'b1;
		node_raddr = n_q;
		cell_waddr = ins_cell;
		cell_raddr = ins_cell;
		cell_wdata = '{occ: 1'b1, head: cell_rd.occ ? cell_rd.head : idx_addr,
		               tail: idx_addr};
		alu_a      = '0;
		alu_b      = '0;
		out_load   = 1'b0;
		ld_found   = 1'b1;
		ld_idx     = gsh_pkg::to_idx(pend_idx_q);
		ld_last    = 1'b0;
		ld_ovf     = 1'b0;
		unique case (state_q)
			gsh_pkg::ST_CLEAR: begin
				cell_we    = 32'(clr_q) < gsh_pkg::GRID_CELLS;
				used_we    = 32'(clr_q) < gsh_pkg::MAX_NODES;
				cell_waddr = clr_q[gsh_pkg::CELL_AW-1:0];
				used_addr  = clr_q[NA-1:0];
				used_wdata = 1'b0;
				cell_wdata = '0;
				if (clr_q == gsh_pkg::CLR_W'(gsh_pkg::CLR_N - 1)) begin
					state_d = gsh_pkg::ST_IDLE;
				end
			end
			gsh_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = gsh_pkg::ST_DECODE;
				end
			end
			gsh_pkg::ST_DECODE: begin
				unique case (cmd_q) inside
					gsh_pkg::CMD_INSERT:                      state_d = gsh_pkg::ST_INS_RD;
					gsh_pkg::CMD_NEAREST, gsh_pkg::CMD_RADIUS: state_d = gsh_pkg::ST_SETUP;
					default:                                  state_d = gsh_pkg::ST_FIN;
				endcase
			end
			gsh_pkg::ST_INS_RD: begin
				used_re = 1'b1;
				cell_re = 1'b1;
				state_d = gsh_pkg::ST_INS_WR;
			end
			gsh_pkg::ST_INS_WR: begin
				xy_we   = !ins_bad;
				used_we = !ins_bad;
				cell_we = !ins_bad;
				nxt_we  = !ins_bad && cell_rd.occ;
				state_d = gsh_pkg::ST_FIN;
			end
			gsh_pkg::ST_SETUP: begin
				alu_a   = gsh_pkg::MUL_W'(rad_q);
				state_d = gsh_pkg::ST_CELL;
			end
			gsh_pkg::ST_CELL: begin
				cell_raddr = {gy_q[GB-1:0], gx_q[GB-1:0]};
				if (in_grid) begin
					cell_re = 1'b1;
					state_d = gsh_pkg::ST_CELL_CHK;
				end else if (adv_done) begin
					state_d = end_st;
				end
			end
			gsh_pkg::ST_CELL_CHK: begin
				if (cell_rd.occ) begin
					state_d = gsh_pkg::ST_NODE_RD;
				end else begin
					state_d = adv_done ? end_st : gsh_pkg::ST_CELL;
				end
			end
			gsh_pkg::ST_NODE_RD: begin
				xy_re   = 1'b1;
				nxt_re  = 1'b1;
				state_d = gsh_pkg::ST_NODE_DX;
			end
			gsh_pkg::ST_NODE_DX: begin
				alu_a   = gsh_pkg::MUL_W'(node_x);
				alu_b   = gsh_pkg::MUL_W'(qx_q);
				state_d = gsh_pkg::ST_NODE_DY;
			end
			gsh_pkg::ST_NODE_DY: begin
				alu_a   = gsh_pkg::MUL_W'(node_y);
				alu_b   = gsh_pkg::MUL_W'(qy_q);
				state_d = gsh_pkg::ST_EVAL;
			end
			gsh_pkg::ST_EVAL: begin
				// Release the previous match once a newer one proves it is not the last
				out_load = need_emit && out_free;
				if (!stall) begin
					if (n_q == tail_q) begin
						state_d = adv_done ? end_st : gsh_pkg::ST_CELL;
					end else begin
						state_d = gsh_pkg::ST_NODE_RD;
					end
				end
			end
			gsh_pkg::ST_RING_SQ: begin
				alu_a   = gsh_pkg::MUL_W'(ext_q);
				state_d = gsh_pkg::ST_RING_CHK;
			end
			gsh_pkg::ST_RING_CHK: begin
				state_d = ring_stop ? gsh_pkg::ST_FIN : gsh_pkg::ST_CELL;
			end
			gsh_pkg::ST_FIN: begin
				ld_last = 1'b1;
				unique case (cmd_q) inside
					gsh_pkg::CMD_NEAREST: begin
						ld_found = have_q;
						ld_idx   = have_q ? gsh_pkg::to_idx(best_idx_q) : '0;
					end
					gsh_pkg::CMD_RADIUS: begin
						ld_found = pend_v_q;
						ld_idx   = pend_v_q ? gsh_pkg::to_idx(pend_idx_q) : '0;
						ld_ovf   = pend_v_q && ovf_q;
					end
					default: begin
						ld_found = res_f_q;
						ld_idx   = res_idx_q;
					end
				endcase
				if (out_free) begin
					out_load = 1'b1;
					state_d  = gsh_pkg::ST_IDLE;
				end
			end
			default: state_d = gsh_pkg::ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gsh_pkg::ST_CLEAR;
			clr_q   <= '0;
			out_v_q <= 1'b0;
			shift_q <= gsh_pkg::SHIFT_W'(12);
			rlim_q  <= gsh_pkg::RING_W'(4);
		end else begin
			state_q <= state_d;
			if (state_q == gsh_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			if (cfg.valid) begin
				unique case (cfg.index)
					gsh_pkg::REG_CELL_SHIFT: shift_q <= cfg.data[gsh_pkg::SHIFT_W-1:0];
					gsh_pkg::REG_RING_LIMIT: rlim_q  <= cfg.data[gsh_pkg::RING_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			o_found_q <= ld_found;
			o_idx_q   <= ld_idx;
			o_last_q  <= ld_last;
			o_ovf_q   <= ld_ovf;
		end
		case (state_q)
			gsh_pkg::ST_IDLE: begin
				cmd_q <= req.cmd;
				qx_q  <= CW'(32'(req.point_x));
				qy_q  <= CW'(32'(req.point_y));
				idx_q <= req.node_index;
				rad_q <= req.radius;
			end
			gsh_pkg::ST_DECODE: begin
				res_f_q   <= 1'b0;
				res_idx_q <= '0;
			end
			gsh_pkg::ST_INS_WR: begin
				res_f_q   <= !ins_bad;
				res_idx_q <= ins_bad ? '0 : idx_q;
			end
			gsh_pkg::ST_SETUP: begin
				r2_q     <= alu_sq[31:0];
				cx_q     <= cxs_c;
				cy_q     <= cys_c;
				ext_q    <= ext_new;
				gx_q     <= cxs_c - ext_new_s;
				gy_q     <= cys_c - ext_new_s;
				have_q   <= 1'b0;
				pend_v_q <= 1'b0;
				cnt_q    <= '0;
				ovf_q    <= 1'b0;
			end
			gsh_pkg::ST_CELL: begin
				if (!in_grid) begin
					gx_q <= gx_n;
					gy_q <= gy_n;
				end
			end
			gsh_pkg::ST_CELL_CHK: begin
				if (cell_rd.occ) begin
					n_q    <= cell_rd.head;
					tail_q <= cell_rd.tail;
				end else begin
					gx_q <= gx_n;
					gy_q <= gy_n;
				end
			end
			gsh_pkg::ST_NODE_DX: begin
				dx2_q <= alu_sq;
			end
			gsh_pkg::ST_NODE_DY: begin
				d_q <= gsh_pkg::DIST_W'({1'b0, dx2_q} + {1'b0, alu_sq});
			end
			gsh_pkg::ST_EVAL: begin
				if (!stall) begin
					if (is_rad) begin
						if (match) begin
							if (32'(cnt_q) < gsh_pkg::MAX_MATCHES) begin
								pend_v_q   <= 1'b1;
								pend_idx_q <= n_q;
								cnt_q      <= cnt_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
						end
					end else if (better) begin
						have_q     <= 1'b1;
						best_q     <= d_q;
						best_idx_q <= n_q;
					end
					if (n_q == tail_q) begin
						gx_q <= gx_n;
						gy_q <= gy_n;
					end else begin
						n_q <= nxt_rd;
					end
				end
			end
			gsh_pkg::ST_RING_SQ: begin
				rsq_q <= alu_sq[2*gsh_pkg::EXT_W-1:0];
			end
			gsh_pkg::ST_RING_CHK: begin
				// Open the next ring at its lower-left corner
				if (!ring_stop) begin
					ext_q <= ext_q + 1'b1;
					gx_q  <= cx_q - ext_inc_s;
					gy_q  <= cy_q - ext_inc_s;
				end
			end
			default: ;
		endcase
	end

	gsh_alu u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.sq (alu_sq)
	);

	gsh_ram #(.WIDTH(2*CW), .DEPTH(gsh_pkg::MAX_NODES)) u_xy_ram (
		.clk   (clk),
		.we    (xy_we),
		.waddr (xy_waddr),
		.wdata ({qx_q, qy_q}),
		.re    (xy_re),
		.raddr (node_raddr),
		.rdata (xy_rd)
	);

	gsh_ram #(.WIDTH(NA), .DEPTH(gsh_pkg::MAX_NODES)) u_nxt_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.re    (nxt_re),
		.raddr (node_raddr),
		.rdata (nxt_rd)
	);

	gsh_ram #(.WIDTH(1), .DEPTH(gsh_pkg::MAX_NODES)) u_used_ram (
		.clk   (clk),
		.we    (used_we),
		.waddr (used_addr),
		.wdata (used_wdata),
		.re    (used_re),
		.raddr (used_addr),
		.rdata (used_rd)
	);

	gsh_ram #(.WIDTH($bits(gsh_pkg::cell_t)), .DEPTH(gsh_pkg::GRID_CELLS)) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.re    (cell_re),
		.raddr (cell_raddr),
		.rdata (cell_rd)
	);

	// Never take a command before the clearing sweep is through
	a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gsh_pkg::ST_CLEAR) |-> !req.ready)
		else $error("command channel ready during clearing sweep");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gsh_pkg::ST_EVAL && is_rad) |-> (32'(cnt_q) <= gsh_pkg::MAX_MATCHES))
		else $error("match count beyond capacity");

	a_mid_beat_found: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.last) |-> (rsp.found && !rsp.overflow))
		else $error("intermediate result beat without a match");

	a_ovf_final: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.overflow) |-> (rsp.found && rsp.last))
		else $error("overflow flag off the final match beat");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result register overwritten while held");
endmodule
`default_nettype wire

// ===== src/gsh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gsh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== src/gsh_alu.sv =====
// Shared unit: absolute difference of two operands, squared.
`default_nettype none
module gsh_alu (
	input  wire logic [gsh_pkg::MUL_W-1:0]   a,
	input  wire logic [gsh_pkg::MUL_W-1:0]   b,
	output logic      [2*gsh_pkg::MUL_W-1:0] sq
);
	logic [gsh_pkg::MUL_W-1:0] diff;

	always_comb begin
		diff = (a > b) ? (a - b) : (b - a);
		sq   = diff * diff;
	end
endmodule
`default_nettype wire

// ===== tb/gsh_checker.sv =====
// Grid spatial hash checker: watches all channels, predicts result beats and compares them.
`timescale 1ns / 1ps
`default_nettype none
module gsh_checker (
	input wire logic clk,
	input wire logic arst_n,
	gsh_req_if       req,
	gsh_rsp_if       rsp,
	gsh_cfg_if       cfg,
	output int       errors,
	output int       pending
);
	import gsh_pkg::*;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
		logic             last;
		logic             ovf;
	} beat_t;

	beat_t want_q[$];

	logic [COORD_BITS-1:0] pt_x [MAX_NODES];
	logic [COORD_BITS-1:0] pt_y [MAX_NODES];
	logic [NODE_AW-1:0]    link [MAX_NODES];
	bit                    used [MAX_NODES];
	logic [NODE_AW-1:0]    head [GRID_CELLS];
	logic [NODE_AW-1:0]    tail [GRID_CELLS];
	bit                    occ  [GRID_CELLS];
	logic [SHIFT_W-1:0]    shift_reg;
	logic [RING_W-1:0]     ring_reg;

	function automatic int eff_shift();
		return (int'(shift_reg) < MIN_SHIFT) ? MIN_SHIFT : int'(shift_reg);
	endfunction

	function automatic longint unsigned sq_dist(int n, int qx, int qy);
		longint unsigned dx, dy;
		dx = (int'(pt_x[n]) > qx) ? int'(pt_x[n]) - qx : qx - int'(pt_x[n]);
		dy = (int'(pt_y[n]) > qy) ? int'(pt_y[n]) - qy : qy - int'(pt_y[n]);
		return dx * dx + dy * dy;
	endfunction

	// Cells beyond the grid count as empty.
	function automatic bit bin_live(int gx, int gy, output int c);
		c = 0;
		if (gx < 0 || gy < 0 || gx >= GRID_SIDE || gy >= GRID_SIDE) return 0;
		c = (gy << GRID_BITS) | gx;
		return occ[c];
	endfunction

	function automatic beat_t mk(logic f, int i, logic l, logic o);
		beat_t b;
		b.found = f;
		b.idx   = IDX_W'(i);
		b.last  = l;
		b.ovf   = o;
		return b;
	endfunction

	// Append one predicted beat to the tail of the queue.
	function automatic void queue_beat(beat_t b);
		want_q = {want_q, b};
	endfunction

	task automatic predict(logic [CMD_W-1:0] cmd_raw, int qx, int qy, int idx, int rad);
		int s, cx, cy, c, n, ring, gx, gy, ax, ay, span, cnt, best_idx;
		bit have, done, ovf;
		longint unsigned best, d, reach, r2;
		beat_t hits[$];
		s  = eff_shift();
		cx = (qx >> s) & (GRID_SIDE - 1);
		cy = (qy >> s) & (GRID_SIDE - 1);
		case (cmd_t'(cmd_raw))
		CMD_INSERT: begin
			if (used[idx]) begin
				queue_beat(mk(0, 0, 1, 0));
			end else begin
				c = (cy << GRID_BITS) | cx;
				pt_x[idx] = COORD_BITS'(qx);
				pt_y[idx] = COORD_BITS'(qy);
				used[idx] = 1;
				if (occ[c]) link[tail[c]] = NODE_AW'(idx);
				else head[c] = NODE_AW'(idx);
				tail[c] = NODE_AW'(idx);
				occ[c] = 1;
				queue_beat(mk(1, idx, 1, 0));
			end
		end
		CMD_NEAREST: begin
			have = 0; done = 0; best = 0; best_idx = 0;
			for (ring = 0; ring <= int'(ring_reg) && !done; ring++) begin
				for (gx = cx - ring; gx <= cx + ring; gx++) begin
					for (gy = cy - ring; gy <= cy + ring; gy++) begin
						ax = (gx > cx) ? gx - cx : cx - gx;
						ay = (gy > cy) ? gy - cy : cy - gy;
						if (((ax > ay) ? ax : ay) != ring) continue;
						if (!bin_live(gx, gy, c)) continue;
						n = head[c];
						forever begin
							d = sq_dist(n, qx, qy);
							// keep the first strictly nearer point
							if (!have || d < best) begin
								have = 1; best = d; best_idx = n;
							end
							if (n == tail[c]) break;
							n = link[n];
						end
					end
				end
				if (have) begin
					reach = longint'(ring) << s;
					if (reach * reach >= best) done = 1;
				end
			end
			queue_beat(mk(have, have ? best_idx : 0, 1, 0));
		end
		CMD_RADIUS: begin
			span = (rad + (1 << s) - 1) >> s;
			r2 = longint'(rad) * longint'(rad);
			cnt = 0; ovf = 0;
			for (gx = cx - span; gx <= cx + span; gx++) begin
				for (gy = cy - span; gy <= cy + span; gy++) begin
					if (!bin_live(gx, gy, c)) continue;
					n = head[c];
					forever begin
						if (sq_dist(n, qx, qy) <= r2) begin
							if (cnt < MAX_MATCHES) begin
								hits = {hits, mk(1, n, 0, 0)};
								cnt++;
							end else ovf = 1;
						end
						if (n == tail[c]) break;
						n = link[n];
					end
				end
			end
			if (cnt == 0) begin
				queue_beat(mk(0, 0, 1, 0));
			end else begin
				hits[cnt-1].last = 1;
				hits[cnt-1].ovf  = ovf;
				foreach (hits[k]) queue_beat(hits[k]);
			end
		end
		default: queue_beat(mk(0, 0, 1, 0));
		endcase
	endtask

	task automatic check_beat(beat_t got);
		beat_t w;
		if (want_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result beat: found=%0b idx=%0d last=%0b ovf=%0b",
					got.found, got.idx, got.last, got.ovf);
			return;
		end
		w = want_q.pop_front();
		if (got !== w) begin
			errors++;
			if (errors <= 10)
				$display({"result mismatch: exp found=%0b idx=%0d last=%0b ovf=%0b,",
					" got found=%0b idx=%0d last=%0b ovf=%0b"},
					w.found, w.idx, w.last, w.ovf, got.found, got.idx, got.last, got.ovf);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (used[i]) used[i] = 0;
			foreach (occ[i]) occ[i] = 0;
			shift_reg = 4'd12;
			ring_reg  = 5'd4;
			want_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (reg_t'(cfg.index))
				REG_CELL_SHIFT: shift_reg = cfg.data[SHIFT_W-1:0];
				REG_RING_LIMIT: ring_reg  = cfg.data[RING_W-1:0];
				default: ;
				endcase
			end
			if (rsp.valid && rsp.ready)
				check_beat({rsp.found, rsp.result_index, rsp.last, rsp.overflow});
			if (req.valid && req.ready)
				predict(req.cmd, int'(req.point_x), int'(req.point_y),
					int'(req.node_index), int'(req.radius));
			pending = want_q.size();
		end
	end
endmodule
`default_nettype wire

// ===== tb/grid_spatial_hash_neighbor_search_tb.sv =====
// Testbench top of the grid spatial hash: stimulus, flow control and the verdict.
`timescale 1ns / 1ps
`default_nettype none
module grid_spatial_hash_neighbor_search_tb;
	import gsh_pkg::*;

	// Watchdog limit, set high to leave room for whole-grid queries under stalls.
	localparam int CYCLE_LIMIT = 20000000;
	localparam int CMD_BAD     = 3;

	logic clk;
	logic arst_n;
	int   errors, pending;
	int   cycles;
	int   burst_left;
	int   accepted;
	bit   hold_off;
	bit   taken [MAX_NODES];

	gsh_req_if req ();
	gsh_rsp_if rsp ();
	gsh_cfg_if cfg ();

	grid_spatial_hash_neighbor_search u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	gsh_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.cfg     (cfg),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Watchdog: end the run if the block hangs.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Receiver: a randomly chosen stall pattern drives ready; a long hold-off overrides it.
	initial begin : rx_flow
		int mode;
		rsp.ready = 0;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (cycles % 64 == 0) mode = $urandom_range(0, 3);
			if (hold_off) rsp.ready <= 1'b0;
			else case (mode)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= ($urandom_range(0, 3) != 0);
			2: rsp.ready <= ($urandom_range(0, 3) == 0);
			default: rsp.ready <= $urandom_range(0, 1);
			endcase
		end
	end

	// Long hold-off once the sender is busy, so the block backs up and stalls its input.
	initial begin : long_hold
		hold_off = 0;
		wait (accepted >= 40);
		@(posedge clk);
		hold_off = 1;
		repeat (400) @(posedge clk);
		hold_off = 0;
	end

	// Send one command beat; valid stays high across back-to-back beats of a burst.
	task automatic send(int cmd, int x, int y, int idx, int rad);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid      <= 1'b1;
		req.cmd        <= CMD_W'(cmd);
		req.point_x    <= FIELD_W'(x);
		req.point_y    <= FIELD_W'(y);
		req.node_index <= IDX_W'(idx);
		req.radius     <= FIELD_W'(rad);
		do @(posedge clk); while (!req.ready);
		accepted++;
		if (cmd == CMD_INSERT) taken[idx] = 1;
	endtask

	task automatic write_reg(reg_t r, int val);
		cfg.valid <= 1'b1;
		cfg.index <= r;
		cfg.data  <= CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	// Drain: drop valid and wait until every expected beat has come back.
	task automatic drain();
		req.valid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic int near(int c, int spread);
		int v;
		v = c + $urandom_range(0, 2 * spread) - spread;
		return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
	endfunction

	// Mostly fresh indices, now and then any index, which may already be stored.
	function automatic int pick_idx();
		int i;
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, MAX_NODES - 1);
		for (int t = 0; t < 50; t++) begin
			i = $urandom_range(0, MAX_NODES - 1);
			if (!taken[i]) return i;
		end
		return i;
	endfunction

	task automatic random_items(int n, int cx, int cy, int spread);
		int k, x, y;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 19);
			x = near(cx, spread);
			y = near(cy, spread);
			if ($urandom_range(0, 7) == 0) begin
				x = $urandom_range(0, 65535);
				y = $urandom_range(0, 65535);
			end
			if (k < 9) send(CMD_INSERT, x, y, pick_idx(), $urandom_range(0, 65535));
			else if (k < 14) send(CMD_NEAREST, x, y, $urandom_range(0, 1023),
				$urandom_range(0, 65535));
			else if (k < 19) send(CMD_RADIUS, x, y, $urandom_range(0, 1023),
				($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 3 * spread));
			else send(CMD_BAD, x, y, $urandom_range(0, 1023), $urandom_range(0, 65535));
		end
	endtask

	initial begin : stimulus
		int sh [5] = '{11, 15, 13, 3, 14};
		int rl [5] = '{0, 31, 7, 2, 16};
		int base;
		arst_n     = 0;
		req.valid  = 0;
		req.cmd    = '0;
		req.point_x = '0;
		req.point_y = '0;
		req.node_index = '0;
		req.radius = '0;
		cfg.valid  = 0;
		cfg.index  = REG_CELL_SHIFT;
		cfg.data   = '0;
		burst_left = 0;
		accepted   = 0;
		foreach (taken[i]) taken[i] = 0;
		repeat (5) @(posedge clk);
		arst_n = 1;
		@(posedge clk);

		// Directed: empty queries, field extremes, re-insert, unknown command.
		send(CMD_NEAREST, 0, 0, 0, 0);
		send(CMD_RADIUS, 65535, 65535, 0, 65535);
		send(CMD_INSERT, 0, 0, 0, 0);
		send(CMD_INSERT, 65535, 65535, 1023, 65535);
		send(CMD_INSERT, 100, 100, 0, 0);
		send(CMD_BAD, 65535, 65535, 1023, 65535);
		send(CMD_INSERT, 4095, 4096, 682, 0);
		send(CMD_INSERT, 4096, 4095, 341, 0);
		send(CMD_NEAREST, 4096, 4096, 0, 0);
		send(CMD_NEAREST, 65535, 0, 0, 0);
		send(CMD_NEAREST, 65535, 65535, 0, 0);
		send(CMD_RADIUS, 0, 0, 0, 0);
		send(CMD_RADIUS, 4096, 4096, 0, 1);
		send(CMD_RADIUS, 30000, 30000, 0, 65535);
		send(CMD_RADIUS, 4096, 4096, 0, 6000);
		drain();

		// Radius overflow: crowd one spot with more than MAX_MATCHES points.
		write_reg(REG_CELL_SHIFT, 15);
		write_reg(REG_RING_LIMIT, 1);
		for (int i = 0; i < MAX_MATCHES + 6; i++)
			send(CMD_INSERT, near(20000, 300), near(20000, 300), pick_idx(), 0);
		send(CMD_RADIUS, 20000, 20000, 0, 1000);
		send(CMD_NEAREST, 20000, 20000, 0, 0);
		drain();

		// Random phases across register settings, including the extremes.
		for (int p = 0; p < 5; p++) begin
			write_reg(REG_CELL_SHIFT, sh[p]);
			write_reg(REG_RING_LIMIT, rl[p]);
			base = $urandom_range(2000, 63000);
			random_items(18, base, $urandom_range(2000, 63000), $urandom_range(200, 6000));
			drain();
		end

		repeat (100) @(posedge clk);
		if (errors == 0 && pending == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
src/gsh_pkg.sv
src/gsh_intf.sv
src/gsh_ram.sv
src/gsh_alu.sv
src/grid_spatial_hash_neighbor_search.sv
tb/gsh_checker.sv
tb/grid_spatial_hash_neighbor_search_tb.sv
